// File: rtl/service_component_list_parser_unit_assert.svh
// assertion macros for the service and component list parser
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef SERVICE_COMPONENT_LIST_PARSER_UNIT_ASSERT_SVH
`define SERVICE_COMPONENT_LIST_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCLP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sclp check failed");

// next-cycle implication, checked outside reset
`define SCLP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sclp check failed");

`endif

// File: rtl/sclp_pkg.sv
// types and constants shared by the service and component list parser
// no dependencies
`timescale 1ns / 1ps

package sclp_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PhId,
    PhCa,
    PhComp1,
    PhComp2
  } phase_e;

  typedef enum logic [1:0] {
    ModeStreamAudio = 2'd0,
    ModeStreamData  = 2'd1,
    ModeReserved    = 2'd2,
    ModePacketData  = 2'd3
  } tmode_e;

  // raw component request from the front part
  typedef struct packed {
    logic [31:0] service_id;
    logic        data_kind;
    logic [2:0]  access_id;
    logic [3:0]  count;
    logic [3:0]  index;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        last;
    logic        no_comp;
  } rec_t;

  // decoded result
  typedef struct packed {
    logic [31:0] service_id;
    logic        programme_service;
    logic [2:0]  access_id;
    logic [3:0]  component_count;
    logic [3:0]  component_index;
    logic [1:0]  transport_mode;
    logic [5:0]  component_type;
    logic [5:0]  subchannel_id;
    logic [11:0] packet_component_id;
    logic        primary_flag;
    logic        access_applied;
    logic        last_of_service;
  } res_t;

endpackage

// File: rtl/sclp_fifo.sv
// small register queue with registered storage, any packed payload type
// depends on nothing but its parameters
`timescale 1ns / 1ps

module sclp_fifo #(
  parameter int unsigned Depth = 2,
  parameter type T = logic [7:0]
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T               mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/sclp_front.sv
// front part: byte framing state machine, gathers service fields and
// component byte pairs into requests; uses sclp_pkg
`timescale 1ns / 1ps

module sclp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          header_start_i,
  input  logic          data_service_i,
  output logic          rec_valid_o,
  output sclp_pkg::rec_t rec_o
);

  import sclp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  id_cnt_q, id_cnt_d;
  logic [31:0] id_acc_q, id_acc_d;
  logic        data_kind_q, data_kind_d;
  logic [2:0]  acc_id_q, acc_id_d;
  logic [3:0]  count_q, count_d;
  logic [3:0]  index_q, index_d;
  logic [7:0]  first_q, first_d;
  logic [1:0]  id_cnt_inc;
  logic [1:0]  id_need;
  logic [3:0]  index_inc;

  assign id_cnt_inc = id_cnt_q + 2'd1;
  // four id bytes wrap the two-bit count back to zero
  assign id_need    = data_kind_q ? 2'd0 : 2'd2;
  assign index_inc  = index_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    id_cnt_d    = id_cnt_q;
    id_acc_d    = id_acc_q;
    data_kind_d = data_kind_q;
    acc_id_d    = acc_id_q;
    count_d     = count_q;
    index_d     = index_q;
    first_d     = first_q;
    rec_valid_o = 1'b0;
    rec_o.service_id  = id_acc_q;
    rec_o.data_kind   = data_kind_q;
    rec_o.access_id   = acc_id_q;
    rec_o.count       = count_q;
    rec_o.index       = index_q;
    rec_o.first_byte  = first_q;
    rec_o.second_byte = data_byte_i;
    rec_o.last        = 1'b0;
    rec_o.no_comp     = 1'b0;

    if (accept_i) begin
      if (header_start_i) begin
        data_kind_d = data_service_i;
        phase_d     = PhId;
        id_cnt_d    = '0;
        id_acc_d    = '0;
      end else begin
        unique case (phase_q)
          PhId: begin
            id_acc_d = {id_acc_q[23:0], data_byte_i};
            if (id_cnt_inc == id_need) begin
              id_cnt_d = '0;
              phase_d  = PhCa;
            end else begin
              id_cnt_d = id_cnt_inc;
            end
          end
          PhCa: begin
            acc_id_d        = data_byte_i[6:4];
            count_d         = data_byte_i[3:0];
            index_d         = '0;
            rec_o.access_id = data_byte_i[6:4];
            rec_o.count     = data_byte_i[3:0];
            rec_o.index     = '0;
            if (data_byte_i[3:0] == 4'd0) begin
              // empty service still reports once
              rec_valid_o   = 1'b1;
              rec_o.last    = 1'b1;
              rec_o.no_comp = 1'b1;
              phase_d       = PhId;
              id_cnt_d      = '0;
              id_acc_d      = '0;
            end else begin
              phase_d = PhComp1;
            end
          end
          PhComp1: begin
            first_d = data_byte_i;
            phase_d = PhComp2;
          end
          PhComp2: begin
            rec_valid_o = 1'b1;
            index_d     = index_inc;
            if (index_inc == count_q) begin
              rec_o.last = 1'b1;
              phase_d    = PhId;
              id_cnt_d   = '0;
              id_acc_d   = '0;
            end else begin
              phase_d = PhComp1;
            end
          end
          default: phase_d = PhId;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhId;
      id_cnt_q    <= '0;
      id_acc_q    <= '0;
      data_kind_q <= 1'b0;
      acc_id_q    <= '0;
      count_q     <= '0;
      index_q     <= '0;
      first_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      id_cnt_q    <= id_cnt_d;
      id_acc_q    <= id_acc_d;
      data_kind_q <= data_kind_d;
      acc_id_q    <= acc_id_d;
      count_q     <= count_d;
      index_q     <= index_d;
      first_q     <= first_d;
    end
  end

endmodule

// File: rtl/sclp_back.sv
// back part: decodes one component request into a result by transport mode
// uses sclp_pkg
`timescale 1ns / 1ps

module sclp_back (
  input  logic           rec_valid_i,
  output logic           rec_ready_o,
  input  sclp_pkg::rec_t rec_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output sclp_pkg::res_t res_o
);

  import sclp_pkg::*;

  logic [1:0] mode;

  assign rec_ready_o = res_ready_i;
  assign res_valid_o = rec_valid_i;
  assign mode        = rec_i.no_comp ? ModeStreamAudio : rec_i.first_byte[7:6];

  always_comb begin
    res_o.service_id          = rec_i.service_id;
    res_o.programme_service   = !rec_i.data_kind;
    res_o.access_id           = rec_i.access_id;
    res_o.component_count     = rec_i.count;
    res_o.component_index     = rec_i.index;
    res_o.transport_mode      = mode;
    res_o.component_type      = '0;
    res_o.subchannel_id       = '0;
    res_o.packet_component_id = '0;
    res_o.primary_flag        = 1'b0;
    res_o.access_applied      = 1'b0;
    res_o.last_of_service     = rec_i.last;
    if (!rec_i.no_comp) begin
      unique case (mode)
        ModeStreamAudio, ModeStreamData: begin
          res_o.component_type = rec_i.first_byte[5:0];
          res_o.subchannel_id  = rec_i.second_byte[7:2];
          res_o.primary_flag   = rec_i.second_byte[1];
          res_o.access_applied = rec_i.second_byte[0];
        end
        ModePacketData: begin
          res_o.packet_component_id = {rec_i.first_byte[5:0], rec_i.second_byte[7:2]};
          res_o.primary_flag        = rec_i.second_byte[1];
          res_o.access_applied      = rec_i.second_byte[0];
        end
        default: begin
          // reserved mode leaves all component fields at zero
          res_o.primary_flag = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/service_component_list_parser_unit.sv
// Service and component list parser, top level.
// Input channel: one list byte per push with header_start_i / data_service_i
// flags; a byte is taken at a clock edge with push high and full low.
// A header byte restarts parsing and sets the service kind (16-bit programme
// id or 32-bit data id); bytes before any header parse as programme services.
// Result channel: the oldest result sits on the result ports while empty is
// low and leaves at an edge with pop high. One result per component, or one
// with zeroed component fields for a service without components.
// A result is registered in the request queue, then in the result queue, before it
// reaches the result ports; a full result queue holds it in the request queue.
// Throughput: one byte per cycle while full is low, set by the framing state
// machine in the front part; each queue holds QueueDepth entries.
// When the receiver stops popping, the result queue fills, then the request
// queue, and full rises; bytes that give no result wait as well.
// Reset clears both queues and puts the framer back to waiting for a
// programme service id.
// Depends on sclp_pkg, sclp_front, sclp_back, sclp_fifo and the assert header.
`timescale 1ns / 1ps

module service_component_list_parser_unit #(
  parameter int unsigned QueueDepth = sclp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        header_start_i,
  input  logic        data_service_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] service_id_o,
  output logic        programme_service_o,
  output logic [2:0]  access_id_o,
  output logic [3:0]  component_count_o,
  output logic [3:0]  component_index_o,
  output logic [1:0]  transport_mode_o,
  output logic [5:0]  component_type_o,
  output logic [5:0]  subchannel_id_o,
  output logic [11:0] packet_component_id_o,
  output logic        primary_flag_o,
  output logic        access_applied_o,
  output logic        last_of_service_o
);

  import sclp_pkg::*;

  logic accept;
  logic front_valid;
  rec_t front_rec;
  logic mid_full, mid_empty;
  rec_t mid_rec;
  logic back_ready;
  logic res_valid;
  res_t res;
  logic out_full;
  res_t out_res;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  sclp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .header_start_i (header_start_i),
    .data_service_i (data_service_i),
    .rec_valid_o    (front_valid),
    .rec_o          (front_rec)
  );

  sclp_fifo #(
    .Depth (QueueDepth),
    .T     (rec_t)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_rec),
    .full_o  (mid_full),
    .pop_i   (back_ready),
    .data_o  (mid_rec),
    .empty_o (mid_empty)
  );

  sclp_back u_back (
    .rec_valid_i (!mid_empty),
    .rec_ready_o (back_ready),
    .rec_i       (mid_rec),
    .res_valid_o (res_valid),
    .res_ready_i (!out_full),
    .res_o       (res)
  );

  sclp_fifo #(
    .Depth (QueueDepth),
    .T     (res_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign service_id_o          = out_res.service_id;
  assign programme_service_o   = out_res.programme_service;
  assign access_id_o           = out_res.access_id;
  assign component_count_o     = out_res.component_count;
  assign component_index_o     = out_res.component_index;
  assign transport_mode_o      = out_res.transport_mode;
  assign component_type_o      = out_res.component_type;
  assign subchannel_id_o       = out_res.subchannel_id;
  assign packet_component_id_o = out_res.packet_component_id;
  assign primary_flag_o        = out_res.primary_flag;
  assign access_applied_o      = out_res.access_applied;
  assign last_of_service_o     = out_res.last_of_service;

  `include "service_component_list_parser_unit_assert.svh"

  // the front only raises a request for a byte it has taken
  `SCLP_ASSERT_IMP(a_req_from_accept, front_valid, accept && !header_start_i)
  // a service without components reports a single zeroed result
  `SCLP_ASSERT_IMP(a_empty_service, !empty && component_count_o == 4'd0,
                   last_of_service_o && transport_mode_o == ModeStreamAudio)
  // the final component of a service carries the highest index
  `SCLP_ASSERT_IMP(a_last_index, !empty && last_of_service_o && component_count_o != 4'd0,
                   component_index_o == 4'(component_count_o - 4'd1))
  // a result that was not popped stays for the next cycle
  `SCLP_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(service_id_o))

endmodule

// File: tb/sv/service_component_checker.sv
// result checker for the service and component list parser: watches both channels,
// predicts every component result from the accepted bytes and compares field by field
// depends on sclp_pkg
`timescale 1ns / 1ps

module service_component_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  logic [7:0]      data_byte_i,
  input  logic            header_start_i,
  input  logic            data_service_i,
  input  logic            empty_i,
  input  logic            pop_i,
  input  sclp_pkg::res_t  result_i,
  output int unsigned     errors_o,
  output int unsigned     pending_o
);
  import sclp_pkg::*;

  phase_e      parse_phase;
  logic [1:0]  id_bytes;
  logic [31:0] id_acc;
  logic        data_kind;
  logic [2:0]  ca_id;
  logic [3:0]  comp_count;
  logic [3:0]  comp_index;
  logic [7:0]  first_byte;

  res_t expected_components[$];
  res_t want;

  task automatic restart_service();
    parse_phase = PhId;
    id_bytes    = '0;
    id_acc      = '0;
  endtask

  task automatic decode_list_byte(input logic [7:0] b, input logic hdr, input logic dsvc);
    res_t   r;
    tmode_e mode;
    logic   emit;
    logic   done;
    r    = '0;
    emit = 1'b0;
    done = 1'b0;
    if (hdr) begin
      data_kind = dsvc;
      done      = 1'b1;
    end else begin
      case (parse_phase)
        PhId: begin
          id_acc   = {id_acc[23:0], b};
          id_bytes = id_bytes + 2'd1;
          // a 4-byte id wraps the 2-bit count back to zero
          if (id_bytes == (data_kind ? 2'd0 : 2'd2)) begin
            id_bytes    = '0;
            parse_phase = PhCa;
          end
        end
        PhCa: begin
          ca_id      = b[6:4];
          comp_count = b[3:0];
          comp_index = '0;
          if (comp_count == 4'd0) begin
            r.last_of_service = 1'b1;
            emit              = 1'b1;
            done              = 1'b1;
          end else begin
            parse_phase = PhComp1;
          end
        end
        PhComp1: begin
          first_byte  = b;
          parse_phase = PhComp2;
        end
        default: begin
          mode              = tmode_e'(first_byte[7:6]);
          r.component_index = comp_index;
          r.transport_mode  = mode;
          case (mode)
            ModeStreamAudio, ModeStreamData: begin
              r.component_type = first_byte[5:0];
              r.subchannel_id  = b[7:2];
            end
            ModePacketData: r.packet_component_id = {first_byte[5:0], b[7:2]};
            default: ;
          endcase
          if (mode != ModeReserved) begin
            r.primary_flag   = b[1];
            r.access_applied = b[0];
          end
          comp_index = comp_index + 4'd1;
          emit       = 1'b1;
          if (comp_index == comp_count) begin
            r.last_of_service = 1'b1;
            done              = 1'b1;
          end else begin
            parse_phase = PhComp1;
          end
        end
      endcase
    end
    if (emit) begin
      r.service_id        = id_acc;
      r.programme_service = !data_kind;
      r.access_id         = ca_id;
      r.component_count   = comp_count;
      expected_components = {expected_components, r};
    end
    if (done) restart_service();
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_service();
      data_kind  = 1'b0;
      ca_id      = '0;
      comp_count = '0;
      comp_index = '0;
      first_byte = '0;
      expected_components.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      // results pass through both queues before they can leave, so check before predicting
      if (pop_i && !empty_i) begin
        if (expected_components.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none, actual service_id %h", $time,
                   result_i.service_id);
        end else begin
          want = expected_components.pop_front();
          check_field("service_id", want.service_id, result_i.service_id);
          check_field("programme_service", 32'(want.programme_service),
                      32'(result_i.programme_service));
          check_field("access_id", 32'(want.access_id), 32'(result_i.access_id));
          check_field("component_count", 32'(want.component_count),
                      32'(result_i.component_count));
          check_field("component_index", 32'(want.component_index),
                      32'(result_i.component_index));
          check_field("transport_mode", 32'(want.transport_mode),
                      32'(result_i.transport_mode));
          check_field("component_type", 32'(want.component_type),
                      32'(result_i.component_type));
          check_field("subchannel_id", 32'(want.subchannel_id),
                      32'(result_i.subchannel_id));
          check_field("packet_component_id", 32'(want.packet_component_id),
                      32'(result_i.packet_component_id));
          check_field("primary_flag", 32'(want.primary_flag), 32'(result_i.primary_flag));
          check_field("access_applied", 32'(want.access_applied),
                      32'(result_i.access_applied));
          check_field("last_of_service", 32'(want.last_of_service),
                      32'(result_i.last_of_service));
        end
      end
      if (push_i && !full_i) decode_list_byte(data_byte_i, header_start_i, data_service_i);
      pending_o = expected_components.size();
    end
  end

endmodule

// File: tb/sv/tb_service_component_list_parser_unit.sv
// top of the service and component list parser testbench: clock, reset, byte stimulus
// and result draining; checking is done by service_component_checker
// depends on sclp_pkg, service_component_checker and the parser rtl
`timescale 1ns / 1ps

module tb_service_component_list_parser_unit;
  import sclp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        header_start;
  logic        data_service;
  logic        empty;
  logic        pop;
  logic [31:0] service_id;
  logic        programme_service;
  logic [2:0]  access_id;
  logic [3:0]  component_count;
  logic [3:0]  component_index;
  logic [1:0]  transport_mode;
  logic [5:0]  component_type;
  logic [5:0]  subchannel_id;
  logic [11:0] packet_component_id;
  logic        primary_flag;
  logic        access_applied;
  logic        last_of_service;

  res_t        seen_component;
  int unsigned errors;
  int unsigned pending;
  int unsigned bytes_sent;
  logic        quiet;
  logic        hold_rx;
  int unsigned hold_left;
  logic        data_list;

  service_component_list_parser_unit i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .push                  (push),
    .full                  (full),
    .data_byte_i           (data_byte),
    .header_start_i        (header_start),
    .data_service_i        (data_service),
    .empty                 (empty),
    .pop                   (pop),
    .service_id_o          (service_id),
    .programme_service_o   (programme_service),
    .access_id_o           (access_id),
    .component_count_o     (component_count),
    .component_index_o     (component_index),
    .transport_mode_o      (transport_mode),
    .component_type_o      (component_type),
    .subchannel_id_o       (subchannel_id),
    .packet_component_id_o (packet_component_id),
    .primary_flag_o        (primary_flag),
    .access_applied_o      (access_applied),
    .last_of_service_o     (last_of_service)
  );

  assign seen_component = {service_id, programme_service, access_id, component_count,
                           component_index, transport_mode, component_type, subchannel_id,
                           packet_component_id, primary_flag, access_applied,
                           last_of_service};

  service_component_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .data_byte_i    (data_byte),
    .header_start_i (header_start),
    .data_service_i (data_service),
    .empty_i        (empty),
    .pop_i          (pop),
    .result_i       (seen_component),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // one list byte per request, held until the parser takes it
  task automatic send_list_byte(input logic [7:0] b, input logic hdr, input logic dsvc);
    if (!quiet) begin
      while ($urandom_range(99) < 23) begin
        push <= 1'b0;
        @(negedge clk_i);
      end
    end
    push         <= 1'b1;
    data_byte    <= b;
    header_start <= hdr;
    data_service <= dsvc;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // one service with random content, optionally cut short
  task automatic send_service(input logic kind, input logic cut);
    logic [7:0] svc_bytes[$];
    int unsigned n_comp;
    int unsigned keep;
    repeat (kind ? 4 : 2) svc_bytes = {svc_bytes, 8'($urandom_range(255))};
    n_comp = ($urandom_range(9) == 0) ? 15 : $urandom_range(4);
    svc_bytes = {svc_bytes, {1'($urandom_range(1)), 3'($urandom_range(7)), 4'(n_comp)}};
    repeat (2 * n_comp) svc_bytes = {svc_bytes, 8'($urandom_range(255))};
    keep = cut ? $urandom_range(svc_bytes.size() - 1) : svc_bytes.size();
    for (int k = 0; k < keep; k++) send_list_byte(svc_bytes[k], 1'b0, 1'($urandom_range(1)));
  endtask

  // receiver: random pops, and a long hold-off when asked
  initial begin
    logic hold_taken;
    pop        = 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rx && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= quiet || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    logic hold_done;
    logic drain_done;
    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte    = '0;
    header_start = 1'b0;
    data_service = 1'b0;
    quiet        = 1'b0;
    hold_rx      = 1'b0;
    bytes_sent   = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // no header yet: programme service with no components
    send_list_byte(8'h12, 1'b0, 1'b0);
    send_list_byte(8'h34, 1'b0, 1'b0);
    send_list_byte(8'h00, 1'b0, 1'b0);
    // programme list, every transport mode, fields at their extremes
    send_list_byte(8'hFF, 1'b1, 1'b0);
    send_list_byte(8'hFF, 1'b0, 1'b1);
    send_list_byte(8'hFF, 1'b0, 1'b1);
    send_list_byte(8'hF4, 1'b0, 1'b1);
    send_list_byte(8'h3F, 1'b0, 1'b1);
    send_list_byte(8'hFF, 1'b0, 1'b1);
    send_list_byte(8'h55, 1'b0, 1'b0);
    send_list_byte(8'hA9, 1'b0, 1'b0);
    send_list_byte(8'hAA, 1'b0, 1'b0);
    send_list_byte(8'hFF, 1'b0, 1'b0);
    send_list_byte(8'hFF, 1'b0, 1'b0);
    send_list_byte(8'hFF, 1'b0, 1'b0);
    // data list with a 32-bit id, one packet component of all zeros
    send_list_byte(8'h00, 1'b1, 1'b1);
    repeat (4) send_list_byte(8'h00, 1'b0, 1'b0);
    send_list_byte(8'h01, 1'b0, 1'b0);
    send_list_byte(8'hC0, 1'b0, 1'b0);
    send_list_byte(8'h00, 1'b0, 1'b0);
    // header arriving mid-service drops the partial service
    send_list_byte(8'h5A, 1'b1, 1'b1);
    send_list_byte(8'h11, 1'b0, 1'b0);
    send_list_byte(8'h22, 1'b0, 1'b0);
    send_list_byte(8'hA5, 1'b1, 1'b0);

    while (bytes_sent < 1500) begin
      if (bytes_sent >= 500 && !hold_done) begin
        hold_done = 1'b1;
        hold_rx   = 1'b1;
      end
      quiet = (bytes_sent >= 650 && bytes_sent < 850);
      if (bytes_sent >= 1100 && !drain_done) begin
        drain_done = 1'b1;
        push <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(99) < 8) begin
        // noise, occasionally with a stray header
        repeat ($urandom_range(1, 6))
          send_list_byte(8'($urandom_range(255)), $urandom_range(9) == 0,
                         1'($urandom_range(1)));
      end else begin
        data_list = 1'($urandom_range(1));
        send_list_byte(8'($urandom_range(255)), 1'b1, data_list);
        repeat ($urandom_range(1, 4)) send_service(data_list, $urandom_range(19) == 0);
      end
    end

    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: service_component_list_parser_unit.f
+incdir+rtl
rtl/sclp_pkg.sv
rtl/sclp_fifo.sv
rtl/sclp_front.sv
rtl/sclp_back.sv
rtl/service_component_list_parser_unit.sv
tb/sv/service_component_checker.sv
tb/sv/tb_service_component_list_parser_unit.sv
